>>> hdl/flc_pkg.sv
// Shared types and constants for the fully associative LRU tag store.
package flc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int BLK_W        = 32;
  localparam int CNT_W        = 32;
  localparam int SIZE_W       = 5;

  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // Per-cell command from the control logic
  typedef struct packed {
    logic upd;      // an access transfer happens this cycle
    logic live;     // cell position is below the fill level
    logic drop_all; // miss with the list full: everything moves toward the LRU end
    logic load;     // this cell takes the incoming block number
  } cell_cmd_t;

endpackage

>>> hdl/flc_cell.sv
// One tag cell of the recency chain: compare, shift from upper neighbor, load.
module flc_cell (
  input  logic                      clk,
  input  logic [flc_pkg::BLK_W-1:0] blk,
  input  flc_pkg::cell_cmd_t        cmd,
  input  logic [flc_pkg::BLK_W-1:0] nbr_tag,
  input  logic                      found_in,
  output logic                      found_out,
  output logic [flc_pkg::BLK_W-1:0] tag_out
);
  import flc_pkg::*;

  logic [BLK_W-1:0] tag_r;
  logic [BLK_W-1:0] tag_nxt;
  logic             shift;

  // found_out ripples up the chain: set at and above the hit position
  assign found_out = found_in | (cmd.live & (tag_r == blk));
  assign shift     = cmd.upd & (found_out | cmd.drop_all);
  assign tag_out   = tag_r;

  always_comb begin
    tag_nxt = tag_r;
    if (cmd.upd && cmd.load) begin
      tag_nxt = blk;
    end else if (shift) begin
      tag_nxt = nbr_tag;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

>>> hdl/flc_stats.sv
// Saturating hit/miss counters and the result register.
module flc_stats (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic                       hit,
  input  logic [flc_pkg::SIZE_W-1:0] fill,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [flc_pkg::CNT_W-1:0]  out_hit_total,
  output logic [flc_pkg::CNT_W-1:0]  out_miss_total,
  output logic [flc_pkg::SIZE_W-1:0] out_fill_level
);
  import flc_pkg::*;

  logic              valid_r, valid_nxt;
  logic              hit_r;
  logic [SIZE_W-1:0] fill_r;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [CNT_W-1:0]  miss_r, miss_nxt;

  always_comb begin
    hits_nxt  = hits_r;
    miss_nxt  = miss_r;
    valid_nxt = valid_r & ~out_ready;
    if (acc) begin
      valid_nxt = 1'b1;
      if (hit && hits_r != CNT_MAX) begin
        hits_nxt = hits_r + 1'b1;
      end
      if (!hit && miss_r != CNT_MAX) begin
        miss_nxt = miss_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hits_r  <= '0;
      miss_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      hits_r  <= hits_nxt;
      miss_r  <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hit_r  <= hit;
      fill_r <= fill;
    end
  end

  assign out_valid      = valid_r;
  assign out_hit        = hit_r;
  assign out_hit_total  = hits_r;
  assign out_miss_total = miss_r;
  assign out_fill_level = fill_r;

endmodule

>>> hdl/fully_associative_lru_cache_tags.sv
// Fully associative tag store with true LRU order, held in a chain of tag cells.
// Lookup, list update and the result register load all complete in the accepting cycle.
// Throughput: one access per cycle, but in_ready falls while a result awaits out_ready.
// The critical path is the tag compare plus the match ripple through all CAPACITY cells.
// Reset (rst_n, synchronous): fill level and counters cleared, size register set to 16.
// Tag cells are not cleared; positions at or above the fill level are never compared.
module fully_associative_lru_cache_tags #(
  parameter int CAPACITY = flc_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [flc_pkg::BLK_W-1:0]  in_block_number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [flc_pkg::CNT_W-1:0]  out_hit_total,
  output logic [flc_pkg::CNT_W-1:0]  out_miss_total,
  output logic [flc_pkg::SIZE_W-1:0] out_fill_level,
  input  logic                       cfg_wr_en,
  input  logic [flc_pkg::SIZE_W-1:0] cfg_wr_data
);
  import flc_pkg::*;

  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > SIZE_W) ? OW : SIZE_W;

  logic [SIZE_W-1:0] size_cfg_r;
  logic [OW-1:0]     occ_r, occ_nxt;
  logic [CW-1:0]     size_eff;
  logic [CW-1:0]     cfg_w;
  logic              acc;
  logic              hit;
  logic              room;
  logic [OW-1:0]     dest;
  logic [SIZE_W-1:0] fill_nxt;

  logic [CAPACITY:0]  found_c;
  logic [BLK_W-1:0]   tag_c [CAPACITY+1];
  cell_cmd_t          cmd_c [CAPACITY];

  assign acc      = in_valid & in_ready;
  assign cfg_w    = CW'(size_cfg_r);

  // Size register clamped to 1..CAPACITY
  always_comb begin
    size_eff = cfg_w;
    if (cfg_w == '0) begin
      size_eff = CW'(1);
    end else if (cfg_w > CW'(CAPACITY)) begin
      size_eff = CW'(CAPACITY);
    end
  end

  assign hit  = found_c[CAPACITY];
  assign room = CW'(occ_r) < size_eff;

  // Write position: the MRU end after the update
  always_comb begin
    if (!hit && room) begin
      dest    = occ_r;
      occ_nxt = occ_r + 1'b1;
    end else begin
      dest    = occ_r - 1'b1;
      occ_nxt = occ_r;
    end
  end

  // Reported fill level is the low bits of the count
  assign fill_nxt = SIZE_W'(occ_nxt);

  assign found_c[0]        = 1'b0;
  assign tag_c[CAPACITY]   = in_block_number;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cmd_c[i].upd      = acc;
    assign cmd_c[i].live     = OW'(i) < occ_r;
    assign cmd_c[i].drop_all = ~hit & ~room;
    assign cmd_c[i].load     = OW'(i) == dest;

    flc_cell u_cell (
      .clk       (clk),
      .blk       (in_block_number),
      .cmd       (cmd_c[i]),
      .nbr_tag   (tag_c[i+1]),
      .found_in  (found_c[i]),
      .found_out (found_c[i+1]),
      .tag_out   (tag_c[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= SIZE_RST;
      occ_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        size_cfg_r <= cfg_wr_data;
      end
      if (acc) begin
        occ_r <= occ_nxt;
      end
    end
  end

  assign in_ready = ~out_valid | out_ready;

  flc_stats u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .hit            (hit),
    .fill           (fill_nxt),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .out_fill_level (out_fill_level)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(CAPACITY))
    else $error("fill level above capacity");

  a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    acc && hit |=> occ_r == $past(occ_r))
    else $error("hit changed fill level");

  a_miss_grows: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !hit && room |=> occ_r == $past(occ_r) + 1'b1)
    else $error("miss with room did not grow list");

  a_hit_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> occ_r != '0)
    else $error("hit on empty list");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid && out_fill_level == $past(fill_nxt))
    else $error("result missing after access transfer");

endmodule

>>> dv/fully_associative_lru_cache_tags_tb.sv
// Self-checking testbench for the fully associative LRU tag store.
module fully_associative_lru_cache_tags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flc_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct {
    logic              hit;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [SIZE_W-1:0] fill_level;
  } lookup_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BLK_W-1:0]    in_block_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic [CNT_W-1:0]    out_hit_total;
  logic [CNT_W-1:0]    out_miss_total;
  logic [SIZE_W-1:0]   out_fill_level;
  logic                cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]   cfg_wr_data = '0;

  fully_associative_lru_cache_tags #(.CAPACITY(CAP)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_block_number (in_block_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total),
    .out_fill_level  (out_fill_level),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: tags ordered LRU first
  logic [BLK_W-1:0]  lru_tags [CAP];
  int unsigned       tag_count = 0;
  logic [CNT_W-1:0]  hits_seen = '0;
  logic [CNT_W-1:0]  misses_seen = '0;
  logic [SIZE_W-1:0] size_reg = SIZE_RST;

  logic [BLK_W-1:0]  pending_blocks [$];
  lookup_result_t    predicted_lookups [$];
  int unsigned       mismatches = 0;

  logic        in_xfer = 1'b0;
  bit          idle_enable = 1'b1;
  bit          long_stall_req = 1'b0;
  bit          long_stall_done = 1'b0;
  int unsigned rx_hold_left = 0;

  function automatic int unsigned size_limit(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > CAP) return CAP;
    return s;
  endfunction

  function automatic void remove_tag(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < tag_count; i++) lru_tags[i] = lru_tags[i + 1];
    tag_count--;
  endfunction

  function automatic lookup_result_t lru_lookup(input logic [BLK_W-1:0] blk);
    lookup_result_t res;
    bit found;
    int unsigned pos;
    found = 1'b0;
    pos = 0;
    for (int unsigned i = 0; i < tag_count; i++) begin
      if (!found && lru_tags[i] == blk) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      if (hits_seen != CNT_MAX) hits_seen++;
      remove_tag(pos);
    end else begin
      if (misses_seen != CNT_MAX) misses_seen++;
      // size may have been lowered below the count: evict and stay at that level
      if (tag_count >= size_limit(size_reg)) remove_tag(0);
    end
    if (tag_count < CAP) begin
      lru_tags[tag_count] = blk;
      tag_count++;
    end
    res.hit = found;
    res.hit_total = hits_seen;
    res.miss_total = misses_seen;
    res.fill_level = tag_count[SIZE_W-1:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_xfer)) begin
      if (pending_blocks.size() != 0 && !(idle_enable && $urandom_range(99) < 9)) begin
        in_block_number <= pending_blocks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_done <= 1'b1;
      rx_hold_left <= 60;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_enable && $urandom_range(99) < 9);
    end
  end

  // Monitor: check the result transfer before predicting this edge's access
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (predicted_lookups.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hit=%0b hits=%0h misses=%0h",
                   $time, out_hit, out_hit_total, out_miss_total);
          mismatches++;
        end else begin
          want = predicted_lookups.pop_front();
          check_field("hit", want.hit, out_hit);
          check_field("hit_total", want.hit_total, out_hit_total);
          check_field("miss_total", want.miss_total, out_miss_total);
          check_field("fill_level", want.fill_level, out_fill_level);
        end
      end
      if (in_valid && in_ready) begin
        predicted_lookups.insert(predicted_lookups.size(), lru_lookup(in_block_number));
      end
    end
  end

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_blocks.size() != 0 || in_valid || predicted_lookups.size() != 0);
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] size_val, input int n,
                           input bit quiet, input bit long_hold);
    logic [BLK_W-1:0] hot [$];
    int unsigned hot_n;
    int unsigned r;
    wait_drained();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size_val;
    size_reg = size_val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    #1;
    idle_enable = !quiet;
    long_stall_req = long_stall_req || long_hold;
    // working set a bit larger than the cache, so hits and evictions mix
    hot_n = size_limit(size_val) + 3;
    hot.delete();
    for (int unsigned i = 0; i < hot_n; i++) hot.insert(hot.size(), $urandom());
    hot[0] = $urandom_range(1) ? '1 : '0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80) pending_blocks.insert(pending_blocks.size(), hot[$urandom_range(hot_n - 1)]);
      else pending_blocks.insert(pending_blocks.size(), $urandom());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;
    // extremes, repeat hits, then fill past the reset size of 16 to force evictions
    pending_blocks = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF};
    for (int i = 1; i <= 12; i++) pending_blocks.insert(pending_blocks.size(), i);
    pending_blocks.insert(pending_blocks.size(), 32'h100);
    pending_blocks.insert(pending_blocks.size(), 32'h200);
    pending_blocks.insert(pending_blocks.size(), 32'h0);
    pending_blocks.insert(pending_blocks.size(), 32'hFFFF_FFFF);
    pending_blocks.insert(pending_blocks.size(), 32'h8000_0000);

    run_phase(5'd4, 45, 1'b0, 1'b0);
    run_phase(5'd0, 40, 1'b0, 1'b0);   // zero acts as one entry
    run_phase(5'd31, 50, 1'b0, 1'b1);  // clamped to capacity
    run_phase(5'd2, 45, 1'b0, 1'b0);   // lowered below the current fill
    run_phase(5'd1, 35, 1'b0, 1'b0);
    run_phase(5'd17, 50, 1'b1, 1'b0);
    run_phase(5'd8, 50, 1'b0, 1'b0);
    run_phase(5'd12, 45, 1'b0, 1'b0);
    run_phase(5'd16, 50, 1'b0, 1'b0);

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout waiting for transfers");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
